[design/aeskg_pkg.sv]
// ----------------------------------------------------------------------------
// aeskg_pkg
// Shared types, constants and byte functions of the AES-128 keystream core.
// ----------------------------------------------------------------------------
package aeskg_pkg;

	localparam int KeyEntries = 22;
	localparam int RkAddrW = 4;
	localparam int PaddrW = 4;

	localparam logic [PaddrW-1:0] RegKeyLow = 4'h0;
	localparam logic [PaddrW-1:0] RegKeyHigh = 4'h8;

	localparam logic [7:0] RconInit = 8'h01;
	localparam logic [7:0] GfPoly = 8'h1b;

	typedef logic [7:0] byte_t;
	typedef logic [127:0] block_t;

	typedef struct packed {
		logic       start;
		logic       restart;
		logic [4:0] used;
	} eng_ctl_t;

	function automatic byte_t sbox(input byte_t a);
		byte_t r;
		unique case (a)
			8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
			8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
			8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
			8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
			8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
			8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
			8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
			8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
			8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
			8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
			8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
			8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
			8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
			8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
			8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
			8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
			8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
			8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
			8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
			8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
			8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
			8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
			8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
			8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
			8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
			8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
			8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
			8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
			8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
			8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
			8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
			8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
			8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
			8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
			8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
			8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
			8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
			8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
			8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
			8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
			8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
			8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
			8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
			8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
			8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
			8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
			8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
			8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
			8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
			8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
			8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
			8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
			8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
			8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
			8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
			8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
			8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
			8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
			8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
			8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
			8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
			8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
			8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
			8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic byte_t xtime(input byte_t v);
		return {v[6:0], 1'b0} ^ (v[7] ? GfPoly : 8'h00);
	endfunction

endpackage

[design/aeskg_if.sv]
// ----------------------------------------------------------------------------
// aeskg_req_if / aeskg_rsp_if
// Valid/ready channels for keystream requests and responses.
// ----------------------------------------------------------------------------
interface aeskg_req_if;
	logic       valid;
	logic       ready;
	logic       restart;
	logic [4:0] valid_bytes;
	modport source (output valid, restart, valid_bytes, input ready);
	modport sink (input valid, restart, valid_bytes, output ready);
endinterface

interface aeskg_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] stream_low;
	logic [63:0] stream_high;
	logic [4:0]  used_bytes;
	modport source (output valid, stream_low, stream_high, used_bytes, input ready);
	modport sink (input valid, stream_low, stream_high, used_bytes, output ready);
endinterface

[design/aeskg_rk_ram.sv]
// ----------------------------------------------------------------------------
// aeskg_rk_ram
// Round key store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module aeskg_rk_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [aeskg_pkg::RkAddrW-1:0] waddr,
	input  logic [127:0]                wdata,
	input  logic [aeskg_pkg::RkAddrW-1:0] raddr,
	output logic [127:0]                rdata
);
	import aeskg_pkg::*;

	logic [127:0] mem [KeyEntries/2];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/aeskg_engine.sv]
// ----------------------------------------------------------------------------
// aeskg_engine
// Sequencer: key expansion into the round key store, then one AES round a
// cycle, each round key being read ahead of its round from the registered port.
// ----------------------------------------------------------------------------
module aeskg_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  aeskg_pkg::eng_ctl_t ctl,
	input  logic [127:0]        key,
	output logic                done,
	output logic [127:0]        result,
	output logic [4:0]          used
);
	import aeskg_pkg::*;

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StExp = 2'd1;
	localparam logic [1:0] StEnc = 2'd2;

	logic [1:0]   state_q;
	logic [3:0]   idx_q;
	logic [127:0] wk_q;
	logic [7:0]   rc_q;
	logic [127:0] st_q;
	logic [63:0]  ctr_q;
	logic [4:0]   used_q;
	logic         we;
	logic [RkAddrW-1:0] waddr, raddr;
	logic [127:0] rk, nk, rnd, ctrblk;
	logic [31:0]  tw;

	aeskg_rk_ram u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wk_q), .raddr(raddr), .rdata(rk)
	);

	assign we = (state_q == StExp);
	assign waddr = idx_q;
	assign raddr = (state_q == StEnc && idx_q != 4'd10) ? idx_q + 4'd1 : '0;

	always_comb begin
		byte_t t [4];
		for (int k = 0; k < 4; k++) t[k] = wk_q[96 + 8*k +: 8];
		tw = {sbox(t[0]), sbox(t[3]), sbox(t[2]), sbox(t[1]) ^ rc_q};
		nk[31:0] = wk_q[31:0] ^ tw;
		nk[63:32] = wk_q[63:32] ^ nk[31:0];
		nk[95:64] = wk_q[95:64] ^ nk[63:32];
		nk[127:96] = wk_q[127:96] ^ nk[95:64];
	end

	always_comb begin
		byte_t s [16];
		byte_t t [16];
		byte_t a0, a1, a2, a3, al;
		for (int i = 0; i < 16; i++) s[i] = st_q[8*i +: 8];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[r + 4*c] = sbox(s[r + 4*((c + r) % 4)]);
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			al = a0 ^ a1 ^ a2 ^ a3;
			if (idx_q != 4'd10) begin
				t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
				t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
				t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
				t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) rnd[8*i +: 8] = t[i] ^ rk[8*i +: 8];
		for (int i = 0; i < 8; i++) begin
			ctrblk[8*i +: 8] = 8'h00;
			ctrblk[64 + 8*i +: 8] = ctr_q[8*(7-i) +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			idx_q <= '0;
			ctr_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				StIdle: begin
					if (ctl.start) begin
						used_q <= ctl.used;
						idx_q <= '0;
						if (ctl.restart) begin
							ctr_q <= '0;
							wk_q <= key;
							rc_q <= RconInit;
							state_q <= StExp;
						end else begin
							state_q <= StEnc;
						end
					end
				end
				StExp: begin
					wk_q <= nk;
					rc_q <= xtime(rc_q);
					if (idx_q == 4'd10) begin
						idx_q <= '0;
						state_q <= StEnc;
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				StEnc: begin
					if (idx_q == 4'd0) begin
						st_q <= ctrblk ^ rk;
						idx_q <= 4'd1;
					end else begin
						st_q <= rnd;
						if (idx_q == 4'd10) begin
							state_q <= StIdle;
							done <= 1'b1;
							ctr_q <= ctr_q + 64'd1;
						end else begin
							idx_q <= idx_q + 4'd1;
						end
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// round 0 reads address 0 in the state's first cycle: prefetch it from idle/expand
	assign result = st_q;
	assign used = used_q;
endmodule

[design/aes128_ctr_keystream_core.sv]
// ----------------------------------------------------------------------------
// aes128_ctr_keystream_core
// AES-128 counter-mode keystream generator with an APB key port.
// ----------------------------------------------------------------------------
// A request without restart runs the initial round key addition, then ten
// rounds, one per cycle through a single round unit fed from the round key
// memory; the result is then registered as the response. A request with
// restart adds key expansion before that, one round key written per cycle. The
// next request is taken once the response register is free or being drained.
module aes128_ctr_keystream_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [aeskg_pkg::PaddrW-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	aeskg_req_if.sink                   req,
	aeskg_rsp_if.source                 rsp
);
	import aeskg_pkg::*;

	logic [63:0]  key_low_q, key_high_q;
	logic         busy_q;
	eng_ctl_t     ctl;
	logic         done;
	logic [127:0] result;
	logic [4:0]   used, sat;
	logic [127:0] masked;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0;
			key_high_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr == RegKeyLow) key_low_q <= pwdata;
			if (paddr == RegKeyHigh) key_high_q <= pwdata;
		end
	end

	always_comb begin
		priority if (paddr == RegKeyLow) prdata = key_low_q;
		else if (paddr == RegKeyHigh) prdata = key_high_q;
		else prdata = '0;
	end

	assign req.ready = !busy_q && (!rsp.valid || rsp.ready);
	assign sat = (req.valid_bytes > 5'd16) ? 5'd16 : req.valid_bytes;
	assign ctl = '{start: req.valid && req.ready, restart: req.restart, used: sat};

	aeskg_engine u_eng (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .key({key_high_q, key_low_q}),
		.done(done), .result(result), .used(used)
	);

	always_comb begin
		for (int i = 0; i < 16; i++)
			masked[8*i +: 8] = (5'(i) < used) ? result[8*i +: 8] : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rsp.valid <= 1'b0;
		end else begin
			if (ctl.start) busy_q <= 1'b1;
			else if (done) busy_q <= 1'b0;
			if (done) rsp.valid <= 1'b1;
			else if (rsp.ready) rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp.stream_low <= masked[63:0];
			rsp.stream_high <= masked[127:64];
			rsp.used_bytes <= used;
		end
	end
endmodule

[design/aeskg_checker.sv]
// ----------------------------------------------------------------------------
// aeskg_port_checker
// Port-level checks of the keystream core, bound to the top level.
// ----------------------------------------------------------------------------
module aeskg_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [4:0] used_bytes,
	input logic       pready
);
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (used_bytes <= 5'd16)) else $error("used_bytes above 16");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready) else $error("second request taken");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");
endmodule

bind aes128_ctr_keystream_core aeskg_port_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .used_bytes(rsp.used_bytes),
	.pready(pready)
);

[tb/tb_aeskg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aeskg_if
// Interfaces are taken from the design interface file; this file holds the
// shared testbench package for item types.
// ----------------------------------------------------------------------------
package tb_aeskg_pkg;

	typedef struct {
		logic [63:0] stream_low;
		logic [63:0] stream_high;
		logic [4:0]  used_bytes;
	} keystream_t;

endpackage

[tb/aeskg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeskg_checker
// Watches the key port and both channels, computes AES-128 counter-mode
// keystream blocks independently and compares every response in order.
// ----------------------------------------------------------------------------
module aeskg_checker
	import aeskg_pkg::*;
	import tb_aeskg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PaddrW-1:0]   paddr,
	input  logic [63:0]         pwdata,
	input  logic                pready,
	input  logic                req_valid,
	input  logic                req_ready,
	input  logic                req_restart,
	input  logic [4:0]          req_valid_bytes,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  logic [63:0]         rsp_stream_low,
	input  logic [63:0]         rsp_stream_high,
	input  logic [4:0]          rsp_used_bytes,
	output int                  errors,
	output int                  pending
);

	logic [63:0] key_lo, key_hi, blk_ctr;
	byte_t rk [0:175];
	keystream_t ks_expected [$];

	function automatic byte_t gmul2(input byte_t v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	task automatic schedule_keys();
		byte_t t [0:3];
		byte_t f;
		byte_t rc;
		rc = 8'h01;
		for (int i = 0; i < 8; i++) begin
			rk[i] = key_lo[8*i +: 8];
			rk[8+i] = key_hi[8*i +: 8];
		end
		for (int i = 4; i < 44; i++) begin
			for (int k = 0; k < 4; k++)
				t[k] = rk[4*(i-1)+k];
			if (i % 4 == 0) begin
				f = t[0];
				t[0] = sbox(t[1]) ^ rc;
				t[1] = sbox(t[2]);
				t[2] = sbox(t[3]);
				t[3] = sbox(f);
				rc = gmul2(rc);
			end
			for (int k = 0; k < 4; k++)
				rk[4*i+k] = rk[4*(i-4)+k] ^ t[k];
		end
	endtask

	function automatic keystream_t keystream_block(input logic [4:0] want);
		byte_t s [0:15];
		byte_t u [0:15];
		byte_t a0, a1, a2, a3, x;
		keystream_t r;
		int n;
		n = (want > 16) ? 16 : want;
		for (int i = 0; i < 8; i++) begin
			s[i] = 8'h00;
			s[8+i] = blk_ctr[8*(7-i) +: 8];
		end
		for (int i = 0; i < 16; i++)
			s[i] ^= rk[i];
		for (int rnd = 1; rnd <= 10; rnd++) begin
			for (int c = 0; c < 4; c++)
				for (int w = 0; w < 4; w++)
					u[w+4*c] = sbox(s[w+4*((c+w)%4)]);
			s = u;
			if (rnd < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
					x = a0 ^ a1 ^ a2 ^ a3;
					s[4*c] = a0 ^ x ^ gmul2(a0 ^ a1);
					s[4*c+1] = a1 ^ x ^ gmul2(a1 ^ a2);
					s[4*c+2] = a2 ^ x ^ gmul2(a2 ^ a3);
					s[4*c+3] = a3 ^ x ^ gmul2(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++)
				s[i] ^= rk[16*rnd+i];
		end
		r.stream_low = '0;
		r.stream_high = '0;
		for (int i = 0; i < 8; i++) begin
			if (i < n)
				r.stream_low[8*i +: 8] = s[i];
			if (8 + i < n)
				r.stream_high[8*i +: 8] = s[8+i];
		end
		r.used_bytes = n[4:0];
		return r;
	endfunction

	initial begin
		errors = 0;
		for (int i = 0; i < 176; i++)
			rk[i] = 8'h00;
	end

	assign pending = ks_expected.size();

	always @(posedge clk or negedge arst_n) begin
		keystream_t got, exp_ks;
		if (!arst_n) begin
			key_lo = '0;
			key_hi = '0;
			blk_ctr = '0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == RegKeyLow)
					key_lo = pwdata;
				else if (paddr == RegKeyHigh)
					key_hi = pwdata;
			end
			if (req_valid && req_ready) begin
				if (req_restart) begin
					schedule_keys();
					blk_ctr = '0;
				end
				ks_expected.push_back(keystream_block(req_valid_bytes));
				blk_ctr = blk_ctr + 64'd1;
			end
			if (rsp_valid && rsp_ready) begin
				got.stream_low = rsp_stream_low;
				got.stream_high = rsp_stream_high;
				got.used_bytes = rsp_used_bytes;
				if (ks_expected.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected response: %h %h %0d", got.stream_high,
							got.stream_low, got.used_bytes);
				end else begin
					exp_ks = ks_expected.pop_front();
					if (got.stream_low !== exp_ks.stream_low ||
							got.stream_high !== exp_ks.stream_high ||
							got.used_bytes !== exp_ks.used_bytes) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %h %h %0d got %h %h %0d",
								exp_ks.stream_high, exp_ks.stream_low, exp_ks.used_bytes,
								got.stream_high, got.stream_low, got.used_bytes);
					end
				end
			end
		end
	end

endmodule

[tb/tb_aes128_ctr_keystream_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aes128_ctr_keystream_core
// Drives key writes and keystream requests with random gaps and stalls; the
// checker beside the core predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_aes128_ctr_keystream_core;
	import aeskg_pkg::*;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [PaddrW-1:0] paddr;
	logic [63:0] pwdata, prdata;
	int errors, pending;
	int idle_pct, hold_cycles;
	bit no_idle;

	aeskg_req_if req ();
	aeskg_rsp_if rsp ();

	aes128_ctr_keystream_core DUT (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req.sink), .rsp(rsp.source)
	);

	aeskg_checker u_checker (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready),
		.req_valid(req.valid), .req_ready(req.ready), .req_restart(req.restart),
		.req_valid_bytes(req.valid_bytes),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_stream_low(rsp.stream_low),
		.rsp_stream_high(rsp.stream_high), .rsp_used_bytes(rsp.used_bytes),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic write_key(input logic [PaddrW-1:0] addr, input logic [63:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic send(input logic rs, input logic [4:0] nb);
		while (!no_idle && $urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.restart <= rs;
		req.valid_bytes <= nb;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp.ready <= 1'b0;
		end else
			rsp.ready <= no_idle || ($urandom_range(99) >= idle_pct);
	end

	initial begin
		logic [4:0] nb;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		req.valid = 0; req.restart = 0; req.valid_bytes = 5'd16;
		rsp.ready = 0;
		idle_pct = 38; no_idle = 0; hold_cycles = 0;
		arst_n = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// FIPS-197 key 000102..0f, then all-one and all-zero keys
		write_key(RegKeyLow, 64'h0706050403020100);
		write_key(RegKeyHigh, 64'h0f0e0d0c0b0a0908);
		send(1'b1, 5'd16);
		for (int i = 0; i <= 16; i++)
			send(1'b0, i[4:0]);
		send(1'b0, 5'd31);
		send(1'b0, 5'd17);
		drain();
		write_key(RegKeyLow, 64'hffffffffffffffff);
		send(1'b0, 5'd16);
		drain();
		write_key(RegKeyHigh, 64'hffffffffffffffff);
		send(1'b1, 5'd16);
		drain();
		write_key(RegKeyLow, '0);
		write_key(RegKeyHigh, '0);
		send(1'b1, 5'd8);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			write_key(RegKeyLow, {$urandom, $urandom});
			write_key(RegKeyHigh, {$urandom, $urandom});
			no_idle = (ph == 2);
			if (ph == 4)
				hold_cycles = 400;
			send(1'b1, 5'($urandom_range(31)));
			for (int i = 0; i < 200; i++) begin
				nb = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
					: 5'($urandom_range(16, 1));
				send($urandom_range(29) == 0, nb);
			end
			no_idle = 0;
			drain();
		end

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[aes128_ctr_keystream_core.f]
design/aeskg_pkg.sv
design/aeskg_if.sv
design/aeskg_rk_ram.sv
design/aeskg_engine.sv
design/aes128_ctr_keystream_core.sv
design/aeskg_checker.sv
tb/tb_aeskg_if.sv
tb/aeskg_checker.sv
tb/tb_aes128_ctr_keystream_core.sv
